// ===== hw/rtl/chm_pkg.sv =====
// Shared types and constants for the chained hash map engine.
// Used by every module of the block but chm_ram; depends on nothing.
`default_nettype none
package chm_pkg;

    localparam int MAX_BUCKETS  = 256;
    localparam int POOL_ENTRIES = 256;
    localparam int VALUE_BITS   = 32;
    localparam int KEY_W        = 32;
    localparam int BKT_AW       = $clog2(MAX_BUCKETS);
    localparam int POOL_AW      = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = POOL_AW + 1;
    localparam int CNT_W        = LINK_W;
    localparam int NB_W         = 9;
    localparam int BIT_CNT_W    = $clog2(KEY_W);

    localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(POOL_ENTRIES);
    localparam logic [KEY_W-1:0]  MIX_MULT  = 32'h045d9f3b;
    localparam int                MIX_SHIFT = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        F_IDLE, F_MUL1, F_MIX2, F_FIN, F_MOD, F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE, B_HEAD, B_CHK, B_CMP, B_ACT, B_ALLOC_RD, B_ALLOC, B_FREE, B_DONE
    } back_state_t;

    // One classified command waiting for the back end.
    typedef struct packed {
        op_t                   op;
        logic [KEY_W-1:0]      key;
        logic [VALUE_BITS-1:0] value;
        logic [BKT_AW-1:0]     bucket;
    } cmd_t;

endpackage
`default_nettype wire

// ===== hw/rtl/chained_hash_map_engine.sv =====
// Top level of the chained hash map engine: configuration register, front end,
// command queue and back end. Depends on chm_pkg, chm_front, chm_queue, chm_back.
//
// The front end takes a new command word only after handing the last one to the
// queue. It mixes the key, reduces it to a bucket by a bit-serial remainder by the
// bucket count and hands it on; clear all skips the hash. The back end takes the
// command from the queue, reads the bucket head, checks and compares each chain
// entry visited and then acts. A new entry adds an allocation step, with a
// free-list read before it when a freed entry is reused; a removal adds a free
// step. Each visit is one registered read of the key, value and link tables, so
// while the back end works on one command the front end is already hashing the
// next. The hand-off stalls only once the two-word queue is full, which takes
// very long chains or a result word held off at the output. Results leave through
// an output register and the block goes on while one waits. Clear all empties the
// table by resetting the per-bucket valid flags.
`default_nettype none
module chained_hash_map_engine (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [8:0]  cfg_data,     // bucket_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,      // key [31:0], value_in [63:32]
    input  wire logic [1:0]  s_tuser,      // opcode [1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,      // value_out [31:0], total_count [40:32], zeros
    output logic [2:0]       m_tuser       // status [1:0], found [2]
);

    logic [chm_pkg::NB_W-1:0] nb_reg, nb_eff;
    logic                     q_push, q_full, q_pop, q_empty;
    chm_pkg::cmd_t            q_in, q_out;
    logic [chm_pkg::VALUE_BITS-1:0] value_out;
    logic [chm_pkg::CNT_W-1:0]      total;
    logic [1:0]                     status;
    logic                           found;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_reg <= chm_pkg::NB_W'(chm_pkg::MAX_BUCKETS);
        end
        else if (cfg_valid)
        begin
            nb_reg <= cfg_data;
        end
    end

    // Zero buckets act as one; anything above the table size saturates.
    always_comb
    begin
        if (nb_reg == '0)
        begin
            nb_eff = chm_pkg::NB_W'(1);
        end
        else if (nb_reg > chm_pkg::NB_W'(chm_pkg::MAX_BUCKETS))
        begin
            nb_eff = chm_pkg::NB_W'(chm_pkg::MAX_BUCKETS);
        end
        else
        begin
            nb_eff = nb_reg;
        end
    end

    chm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready), .in_op(s_tuser),
        .in_key(s_tdata[31:0]), .in_value(s_tdata[63:32]),
        .nb(nb_eff), .q_push(q_push), .q_data(q_in), .q_full(q_full)
    );

    chm_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .pop_data(q_out), .empty(q_empty)
    );

    chm_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(q_empty), .q_pop(q_pop), .q_data(q_out),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_status(status), .out_found(found),
        .out_value(value_out), .out_total(total)
    );

    assign m_tdata = {7'b0, total, value_out};
    assign m_tuser = {found, status};

endmodule
`default_nettype wire

// ===== hw/rtl/chm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used for every table of the hash map.
`default_nettype none
module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/chm_queue.sv =====
// Two-word command queue between the front end and the back end.
// Depends on chm_pkg for the command type.
`default_nettype none
module chm_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire chm_pkg::cmd_t push_data,
    output logic               full,
    input  wire logic          pop,
    output chm_pkg::cmd_t      pop_data,
    output logic               empty
);

    chm_pkg::cmd_t slot_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    fill_reg, fill_next;

    assign full     = (fill_reg == 2'd2);
    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/chm_front.sv =====
// Front end: accepts command words, mixes the key and reduces it to a bucket.
// Depends on chm_pkg; feeds chm_queue.
`default_nettype none
module chm_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [1:0]                      in_op,
    input  wire logic [chm_pkg::KEY_W-1:0]       in_key,
    input  wire logic [chm_pkg::VALUE_BITS-1:0]  in_value,
    input  wire logic [chm_pkg::NB_W-1:0]        nb,
    output logic                                 q_push,
    output chm_pkg::cmd_t                        q_data,
    input  wire logic                            q_full
);

    chm_pkg::front_state_t state_reg, state_next;

    chm_pkg::op_t                      op_reg, op_next;
    logic [chm_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [chm_pkg::VALUE_BITS-1:0]    val_reg, val_next;
    logic [chm_pkg::KEY_W-1:0]         x_reg, x_next;
    logic [chm_pkg::BKT_AW-1:0]        rem_reg, rem_next;
    logic [chm_pkg::BIT_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [chm_pkg::BKT_AW:0]          trial;
    logic [chm_pkg::KEY_W-1:0]         x_fold;

    assign x_fold = x_reg ^ (x_reg >> chm_pkg::MIX_SHIFT);
    assign trial  = {rem_reg, x_reg[chm_pkg::KEY_W-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chm_pkg::F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (chm_pkg::op_t'(in_op) == chm_pkg::OP_CLEAR) ?
                                 chm_pkg::F_PUSH : chm_pkg::F_MUL1;
                end
            end
            chm_pkg::F_MUL1: state_next = chm_pkg::F_MIX2;
            chm_pkg::F_MIX2: state_next = chm_pkg::F_FIN;
            chm_pkg::F_FIN:  state_next = chm_pkg::F_MOD;
            chm_pkg::F_MOD:
            begin
                if (cnt_reg == chm_pkg::BIT_CNT_W'(chm_pkg::KEY_W - 1))
                begin
                    state_next = chm_pkg::F_PUSH;
                end
            end
            chm_pkg::F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = chm_pkg::F_IDLE;
                end
            end
            default: state_next = chm_pkg::F_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == chm_pkg::F_IDLE);
        q_push        = (state_reg == chm_pkg::F_PUSH) && !q_full;
        q_data.op     = op_reg;
        q_data.key    = key_reg;
        q_data.value  = val_reg;
        q_data.bucket = rem_reg;
    end

    // Datapath: two mix rounds, a final fold, then a one-bit-a-cycle remainder.
    always_comb
    begin
        op_next  = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        x_next   = x_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            chm_pkg::F_IDLE:
            begin
                op_next  = chm_pkg::op_t'(in_op);
                key_next = in_key;
                val_next = in_value;
                x_next   = in_key ^ (in_key >> chm_pkg::MIX_SHIFT);
            end
            chm_pkg::F_MUL1: x_next = x_reg * chm_pkg::MIX_MULT;
            chm_pkg::F_MIX2: x_next = x_fold * chm_pkg::MIX_MULT;
            chm_pkg::F_FIN:
            begin
                x_next   = x_fold;
                rem_next = '0;
                cnt_next = '0;
            end
            chm_pkg::F_MOD:
            begin
                x_next   = {x_reg[chm_pkg::KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if ({1'b0, trial} >= {{(chm_pkg::BKT_AW + 1 - chm_pkg::NB_W + 1){1'b0}},
                                      nb})
                begin
                    rem_next = chm_pkg::BKT_AW'(trial - (chm_pkg::BKT_AW + 1)'(nb));
                end
                else
                begin
                    rem_next = trial[chm_pkg::BKT_AW-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= chm_pkg::F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        x_reg   <= x_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/chm_back.sv =====
// Back end: walks a bucket chain and performs insert, lookup, remove or clear.
// Depends on chm_pkg and chm_ram; takes commands from chm_queue.
`default_nettype none
module chm_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            q_empty,
    output logic                                 q_pop,
    input  wire chm_pkg::cmd_t                   q_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [1:0]                           out_status,
    output logic                                 out_found,
    output logic [chm_pkg::VALUE_BITS-1:0]       out_value,
    output logic [chm_pkg::CNT_W-1:0]            out_total
);

    localparam int AW = chm_pkg::POOL_AW;
    localparam int LW = chm_pkg::LINK_W;
    localparam int BW = chm_pkg::BKT_AW;
    localparam int VW = chm_pkg::VALUE_BITS;
    localparam int KW = chm_pkg::KEY_W;

    chm_pkg::back_state_t state_reg, state_next;

    chm_pkg::op_t        op_reg, op_next;
    logic [KW-1:0]       key_reg, key_next;
    logic [VW-1:0]       val_reg, val_next;
    logic [BW-1:0]       bkt_reg, bkt_next;
    logic [LW-1:0]       cur_reg, cur_next;
    logic [LW-1:0]       prev_reg, prev_next;
    logic [LW-1:0]       nxt_reg, nxt_next;
    logic [LW-1:0]       head_reg, head_next;
    logic [LW-1:0]       steps_reg, steps_next;
    logic [LW-1:0]       alloc_reg, alloc_next;
    logic [VW-1:0]       vout_reg, vout_next;
    logic                hit_reg, hit_next;
    chm_pkg::status_t    res_reg, res_next;
    logic [LW-1:0]       free_reg, free_next;
    logic [LW-1:0]       fresh_reg, fresh_next;
    logic [chm_pkg::CNT_W-1:0] total_reg, total_next;
    logic [chm_pkg::MAX_BUCKETS-1:0] hv_reg, hv_next;

    logic                ovalid_reg, ovalid_next;
    logic [1:0]          ostat_reg, ostat_next;
    logic                ofound_reg, ofound_next;
    logic [VW-1:0]       oval_reg, oval_next;
    logic [chm_pkg::CNT_W-1:0] ototal_reg, ototal_next;

    logic          head_we, head_re;
    logic [BW-1:0] head_wa, head_ra;
    logic [LW-1:0] head_wd, head_rd;
    logic          key_we, val_we, next_we, ent_re, next_re;
    logic [AW-1:0] ent_wa, next_wa, ent_ra, next_ra;
    logic [KW-1:0] key_rd;
    logic [VW-1:0] val_rd;
    logic [LW-1:0] next_wd, next_rd;

    logic cur_ok, key_hit, out_load;

    assign cur_ok   = (cur_reg < chm_pkg::NIL_LINK) &&
                      (steps_reg < LW'(chm_pkg::POOL_ENTRIES));
    assign key_hit  = (key_rd == key_reg);
    assign out_load = !ovalid_reg || out_ready;

    chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::MAX_BUCKETS)) u_head_ram (
        .clk(clk), .wr_en(head_we), .wr_addr(head_wa), .wr_data(head_wd),
        .rd_en(head_re), .rd_addr(head_ra), .rd_data(head_rd)
    );
    chm_ram #(.WIDTH(KW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_key_ram (
        .clk(clk), .wr_en(key_we), .wr_addr(ent_wa), .wr_data(key_reg),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(key_rd)
    );
    chm_ram #(.WIDTH(VW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_val_ram (
        .clk(clk), .wr_en(val_we), .wr_addr(ent_wa), .wr_data(val_reg),
        .rd_en(ent_re), .rd_addr(ent_ra), .rd_data(val_rd)
    );
    chm_ram #(.WIDTH(LW), .DEPTH(chm_pkg::POOL_ENTRIES)) u_next_ram (
        .clk(clk), .wr_en(next_we), .wr_addr(next_wa), .wr_data(next_wd),
        .rd_en(next_re), .rd_addr(next_ra), .rd_data(next_rd)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            chm_pkg::B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (q_data.op == chm_pkg::OP_CLEAR) ?
                                 chm_pkg::B_DONE : chm_pkg::B_HEAD;
                end
            end
            chm_pkg::B_HEAD: state_next = chm_pkg::B_CHK;
            chm_pkg::B_CHK:  state_next = cur_ok ? chm_pkg::B_CMP : chm_pkg::B_ACT;
            chm_pkg::B_CMP:  state_next = key_hit ? chm_pkg::B_ACT : chm_pkg::B_CHK;
            chm_pkg::B_ACT:
            begin
                state_next = chm_pkg::B_DONE;
                if (op_reg == chm_pkg::OP_INSERT && !hit_reg &&
                    free_reg != chm_pkg::NIL_LINK)
                begin
                    state_next = (free_reg == fresh_reg) ?
                                 chm_pkg::B_ALLOC : chm_pkg::B_ALLOC_RD;
                end
                else if (op_reg == chm_pkg::OP_REMOVE && hit_reg)
                begin
                    state_next = chm_pkg::B_FREE;
                end
            end
            chm_pkg::B_ALLOC_RD: state_next = chm_pkg::B_ALLOC;
            chm_pkg::B_ALLOC:    state_next = chm_pkg::B_DONE;
            chm_pkg::B_FREE:     state_next = chm_pkg::B_DONE;
            chm_pkg::B_DONE:
            begin
                if (out_load)
                begin
                    state_next = chm_pkg::B_IDLE;
                end
            end
            default: state_next = chm_pkg::B_IDLE;
        endcase
    end

    // Memory port control for each state.
    always_comb
    begin
        q_pop   = 1'b0;
        head_we = 1'b0;
        head_wa = bkt_reg;
        head_wd = nxt_reg;
        head_re = 1'b0;
        head_ra = q_data.bucket;
        key_we  = 1'b0;
        val_we  = 1'b0;
        ent_wa  = cur_reg[AW-1:0];
        ent_re  = 1'b0;
        ent_ra  = cur_reg[AW-1:0];
        next_we = 1'b0;
        next_wa = prev_reg[AW-1:0];
        next_wd = nxt_reg;
        next_re = 1'b0;
        next_ra = cur_reg[AW-1:0];
        unique case (state_reg)
            chm_pkg::B_IDLE:
            begin
                q_pop   = !q_empty;
                head_re = !q_empty;
            end
            chm_pkg::B_CHK:
            begin
                ent_re  = cur_ok;
                next_re = cur_ok;
            end
            chm_pkg::B_ACT:
            begin
                if (op_reg == chm_pkg::OP_INSERT && hit_reg)
                begin
                    val_we = 1'b1;
                end
                else if (op_reg == chm_pkg::OP_INSERT)
                begin
                    next_re = 1'b1;
                    next_ra = free_reg[AW-1:0];
                end
                else if (op_reg == chm_pkg::OP_REMOVE && hit_reg)
                begin
                    // Unlink from the predecessor, or from the bucket head.
                    if (prev_reg != chm_pkg::NIL_LINK)
                    begin
                        next_we = 1'b1;
                    end
                    else
                    begin
                        head_we = 1'b1;
                    end
                end
            end
            chm_pkg::B_ALLOC:
            begin
                key_we  = 1'b1;
                val_we  = 1'b1;
                ent_wa  = alloc_reg[AW-1:0];
                next_we = 1'b1;
                next_wa = alloc_reg[AW-1:0];
                next_wd = head_reg;
                head_we = 1'b1;
                head_wd = alloc_reg;
            end
            chm_pkg::B_FREE:
            begin
                next_we = 1'b1;
                next_wa = cur_reg[AW-1:0];
                next_wd = free_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        bkt_next    = bkt_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        nxt_next    = nxt_reg;
        head_next   = head_reg;
        steps_next  = steps_reg;
        alloc_next  = alloc_reg;
        vout_next   = vout_reg;
        hit_next    = hit_reg;
        res_next    = res_reg;
        free_next   = free_reg;
        fresh_next  = fresh_reg;
        total_next  = total_reg;
        hv_next     = hv_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ostat_next  = ostat_reg;
        ofound_next = ofound_reg;
        oval_next   = oval_reg;
        ototal_next = ototal_reg;
        if (head_we)
        begin
            hv_next[head_wa] = 1'b1;
        end
        unique case (state_reg)
            chm_pkg::B_IDLE:
            begin
                op_next  = q_data.op;
                key_next = q_data.key;
                val_next = q_data.value;
                bkt_next = q_data.bucket;
                hit_next = 1'b0;
                res_next = chm_pkg::ST_OK;
                if (!q_empty && q_data.op == chm_pkg::OP_CLEAR)
                begin
                    // Free list restarts as the untouched pool in index order.
                    hv_next    = '0;
                    free_next  = '0;
                    fresh_next = '0;
                    total_next = '0;
                end
            end
            chm_pkg::B_HEAD:
            begin
                head_next  = hv_reg[bkt_reg] ? head_rd : chm_pkg::NIL_LINK;
                cur_next   = hv_reg[bkt_reg] ? head_rd : chm_pkg::NIL_LINK;
                prev_next  = chm_pkg::NIL_LINK;
                steps_next = '0;
            end
            chm_pkg::B_CMP:
            begin
                if (key_hit)
                begin
                    hit_next  = 1'b1;
                    nxt_next  = next_rd;
                    vout_next = val_rd;
                end
                else
                begin
                    prev_next  = cur_reg;
                    cur_next   = next_rd;
                    steps_next = steps_reg + 1'b1;
                end
            end
            chm_pkg::B_ACT:
            begin
                if (op_reg == chm_pkg::OP_INSERT && !hit_reg)
                begin
                    alloc_next = free_reg;
                    if (free_reg == chm_pkg::NIL_LINK)
                    begin
                        res_next = chm_pkg::ST_FULL;
                    end
                    else if (free_reg == fresh_reg)
                    begin
                        free_next  = fresh_reg + 1'b1;
                        fresh_next = fresh_reg + 1'b1;
                    end
                end
                else if (op_reg != chm_pkg::OP_INSERT && !hit_reg)
                begin
                    res_next = chm_pkg::ST_MISSING;
                end
            end
            chm_pkg::B_ALLOC_RD: free_next = next_rd;
            chm_pkg::B_ALLOC:    total_next = total_reg + 1'b1;
            chm_pkg::B_FREE:
            begin
                free_next = cur_reg;
                if (total_reg != '0)
                begin
                    total_next = total_reg - 1'b1;
                end
            end
            chm_pkg::B_DONE:
            begin
                if (out_load)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = res_reg;
                    ofound_next = (op_reg == chm_pkg::OP_LOOKUP) && hit_reg;
                    oval_next   = ((op_reg == chm_pkg::OP_LOOKUP) && hit_reg) ?
                                  vout_reg : '0;
                    ototal_next = total_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid  = ovalid_reg;
    assign out_status = ostat_reg;
    assign out_found  = ofound_reg;
    assign out_value  = oval_reg;
    assign out_total  = ototal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chm_pkg::B_IDLE;
            free_reg   <= '0;
            fresh_reg  <= '0;
            total_reg  <= '0;
            hv_reg     <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            free_reg   <= free_next;
            fresh_reg  <= fresh_next;
            total_reg  <= total_next;
            hv_reg     <= hv_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        bkt_reg    <= bkt_next;
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        nxt_reg    <= nxt_next;
        head_reg   <= head_next;
        steps_reg  <= steps_next;
        alloc_reg  <= alloc_next;
        vout_reg   <= vout_next;
        hit_reg    <= hit_next;
        res_reg    <= res_next;
        ostat_reg  <= ostat_next;
        ofound_reg <= ofound_next;
        oval_reg   <= oval_next;
        ototal_reg <= ototal_next;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/chm_checker.sv =====
// Port-level checks on the chained hash map engine, bound to the top level.
// Depends on the top level's ports and on chm_pkg for the status codes.
`default_nettype none
module chm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic [2:0]  m_tuser
);

    // A result word waits until it is taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word dropped before it was taken");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tuser[1:0] == chm_pkg::ST_OK)
        else $error("found flag with a failing status");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[2] |-> m_tdata[31:0] == 32'd0)
        else $error("value returned without a hit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1:0] <= chm_pkg::ST_FULL)
        else $error("undefined status code");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[40:32] <= 9'(chm_pkg::POOL_ENTRIES))
        else $error("entry count beyond the pool size");

endmodule

bind chained_hash_map_engine chm_checker u_chm_checker (
    .clk(clk), .rst_n(rst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the chained hash map engine.
// Drives command words with a behavioural map model and checks every result word.
// Depends on chm_pkg and the chained_hash_map_engine top level.
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [2:0]  m_tuser;

    chained_hash_map_engine dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    typedef struct packed {
        chm_pkg::status_t status;
        logic             found;
        logic [31:0]      value;
        logic [8:0]       total;
    } reply_t;

    // Model of the map.
    logic [8:0]  map_nb;
    logic [8:0]  map_head [chm_pkg::MAX_BUCKETS];
    logic [31:0] map_key  [chm_pkg::POOL_ENTRIES];
    logic [31:0] map_val  [chm_pkg::POOL_ENTRIES];
    logic [8:0]  map_next [chm_pkg::POOL_ENTRIES];
    logic [8:0]  map_free;
    logic [8:0]  map_total;

    reply_t replies_due [$];
    int     errors;
    int     cycles;
    int     send_idle_pct;
    int     recv_idle_pct;
    int     hold_off;
    logic [31:0] used_keys [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [31:0] mix_key(logic [31:0] k);
        k = ((k >> chm_pkg::MIX_SHIFT) ^ k) * chm_pkg::MIX_MULT;
        k = ((k >> chm_pkg::MIX_SHIFT) ^ k) * chm_pkg::MIX_MULT;
        return (k >> chm_pkg::MIX_SHIFT) ^ k;
    endfunction

    function automatic void map_empty();
        for (int i = 0; i < chm_pkg::MAX_BUCKETS; i++)
            map_head[i] = chm_pkg::NIL_LINK;
        for (int i = 0; i < chm_pkg::POOL_ENTRIES; i++)
            map_next[i] = (i + 1 < chm_pkg::POOL_ENTRIES) ? 9'(i + 1) : chm_pkg::NIL_LINK;
        map_free  = 0;
        map_total = 0;
    endfunction

    function automatic reply_t map_apply(chm_pkg::op_t op, logic [31:0] k, logic [31:0] v);
        reply_t r;
        int nb, b, steps;
        logic [8:0] prev, cur, n;
        logic hit;
        r = '{status: chm_pkg::ST_OK, found: 1'b0, value: 32'd0, total: 9'd0};
        if (op == chm_pkg::OP_CLEAR)
            map_empty();
        else
        begin
            nb = (map_nb == 0) ? 1 :
                 (map_nb > chm_pkg::MAX_BUCKETS ? chm_pkg::MAX_BUCKETS : map_nb);
            b = mix_key(k) % nb;
            prev = chm_pkg::NIL_LINK;
            cur = map_head[b];
            steps = 0;
            while (cur < chm_pkg::POOL_ENTRIES && steps < chm_pkg::POOL_ENTRIES
                   && map_key[cur] != k)
            begin
                prev = cur;
                cur = map_next[cur];
                steps++;
            end
            hit = cur < chm_pkg::POOL_ENTRIES && steps < chm_pkg::POOL_ENTRIES;
            case (op)
                chm_pkg::OP_INSERT:
                    if (hit)
                        map_val[cur] = v;
                    else if (map_free >= chm_pkg::POOL_ENTRIES)
                        r.status = chm_pkg::ST_FULL;
                    else
                    begin
                        n = map_free;
                        map_free = map_next[n];
                        map_key[n] = k;
                        map_val[n] = v;
                        map_next[n] = map_head[b];
                        map_head[b] = n;
                        map_total++;
                    end
                chm_pkg::OP_LOOKUP:
                    if (hit)
                    begin
                        r.found = 1'b1;
                        r.value = map_val[cur];
                    end
                    else
                        r.status = chm_pkg::ST_MISSING;
                default:
                    if (hit)
                    begin
                        if (prev < chm_pkg::POOL_ENTRIES)
                            map_next[prev] = map_next[cur];
                        else
                            map_head[b] = map_next[cur];
                        map_next[cur] = map_free;
                        map_free = cur;
                        if (map_total > 0)
                            map_total--;
                    end
                    else
                        r.status = chm_pkg::ST_MISSING;
            endcase
        end
        r.total = map_total;
        return r;
    endfunction

    // The word stays offered after acceptance until the next falling edge, where
    // either the next word or an idle cycle replaces it.
    task automatic send_command(chm_pkg::op_t op, logic [31:0] k, logic [31:0] v);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {v, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        replies_due.push_back(map_apply(op, k, v));
        if (k != 0)
            used_keys.push_back(k);
        if (used_keys.size() > 64)
            void'(used_keys.pop_front());
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (replies_due.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_buckets(logic [8:0] nb);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= nb;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        map_nb = nb;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver side: random stalls, or a long hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off > 0)
        begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (replies_due.size() == 0)
            begin
                $display("%0t: unexpected result word %h %h", $time, m_tuser, m_tdata);
                errors++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (m_tuser[1:0] != want.status || m_tuser[2] != want.found
                    || m_tdata[31:0] != want.value || m_tdata[40:32] != want.total
                    || m_tdata[47:41] != 7'd0)
                begin
                    $display({"%0t: expected st=%0d f=%0d v=%h n=%0d,",
                              " got st=%0d f=%0d v=%h n=%0d"},
                        $time, want.status, want.found, want.value, want.total,
                        m_tuser[1:0], m_tuser[2], m_tdata[31:0], m_tdata[40:32]);
                    errors++;
                end
            end
        end
    end

    function automatic logic [31:0] pick_key();
        if (used_keys.size() > 0 && $urandom_range(99) < 60)
            return used_keys[$urandom_range(used_keys.size() - 1)];
        return ($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(40));
    endfunction

    task automatic test_directed();
        send_command(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_command(chm_pkg::OP_REMOVE, 32'hFFFFFFFF, 32'h0);
        send_command(chm_pkg::OP_INSERT, 32'h0, 32'hFFFFFFFF);
        send_command(chm_pkg::OP_INSERT, 32'hFFFFFFFF, 32'h0);
        send_command(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_command(chm_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h12345678);
        send_command(chm_pkg::OP_INSERT, 32'h0, 32'hA5A5A5A5);
        send_command(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_command(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
        send_command(chm_pkg::OP_LOOKUP, 32'h0, 32'h0);
        send_command(chm_pkg::OP_REMOVE, 32'h0, 32'h0);
        send_command(chm_pkg::OP_CLEAR, 32'hFFFFFFFF, 32'hFFFFFFFF);
        send_command(chm_pkg::OP_LOOKUP, 32'hFFFFFFFF, 32'h0);
    endtask

    // One bucket forces every key onto one chain, so removals hit its middle, tail and head.
    task automatic test_single_chain();
        write_buckets(9'd1);
        for (int i = 0; i < 6; i++)
            send_command(chm_pkg::OP_INSERT, 32'(i * 7 + 1), $urandom);
        send_command(chm_pkg::OP_REMOVE, 32'd15, 32'd0);
        send_command(chm_pkg::OP_REMOVE, 32'd1, 32'd0);
        send_command(chm_pkg::OP_REMOVE, 32'd36, 32'd0);
        send_command(chm_pkg::OP_LOOKUP, 32'd22, 32'd0);
        send_command(chm_pkg::OP_CLEAR, 32'd0, 32'd0);
        write_buckets(9'd0);
        send_command(chm_pkg::OP_INSERT, 32'd5, 32'd9);
        send_command(chm_pkg::OP_LOOKUP, 32'd5, 32'd0);
    endtask

    // Fill the whole pool, then update a present key and insert one more.
    task automatic test_pool_full();
        write_buckets(9'd511);
        send_command(chm_pkg::OP_CLEAR, 32'd0, 32'd0);
        for (int i = 0; i < chm_pkg::POOL_ENTRIES; i++)
            send_command(chm_pkg::OP_INSERT, 32'(i + 1000), $urandom);
        send_command(chm_pkg::OP_INSERT, 32'd1003, 32'hDEADBEEF);
        send_command(chm_pkg::OP_INSERT, 32'd99999, 32'h1);
        send_command(chm_pkg::OP_LOOKUP, 32'd1003, 32'd0);
        write_buckets(9'd3);
        send_command(chm_pkg::OP_LOOKUP, 32'd1100, 32'd0);
        send_command(chm_pkg::OP_CLEAR, 32'd0, 32'd0);
    endtask

    task automatic test_back_pressure();
        hold_off = 400;
        for (int i = 0; i < 12; i++)
            send_command(chm_pkg::op_t'($urandom_range(2)), pick_key(), $urandom);
        wait_drained();
    endtask

    task automatic test_random(int count);
        int r;
        chm_pkg::op_t op;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            op = (r < 45) ? chm_pkg::OP_INSERT :
                 (r < 75) ? chm_pkg::OP_LOOKUP :
                 (r < 98) ? chm_pkg::OP_REMOVE : chm_pkg::OP_CLEAR;
            send_command(op, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_off = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 9'd0;
        s_tvalid = 1'b0;
        s_tdata = 64'd0;
        s_tuser = 2'd0;
        map_nb = 9'd256;
        map_empty();
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_single_chain();
        send_idle_pct = 33;
        recv_idle_pct = 51;
        test_pool_full();
        test_back_pressure();
        write_buckets(9'd7);
        test_random(60);
        send_idle_pct = 51;
        recv_idle_pct = 33;
        write_buckets(9'd256);
        test_random(60);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_buckets(9'd2);
        test_random(60);

        wait_drained();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
